>>> src/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared constants and types of the feedback frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int FRAME_LEN  = 24;
	localparam int CHECK_POS  = 22;
	localparam int TAIL_POS   = 23;
	localparam int WORD_COUNT = 10;
	localparam int FILL_W     = 5;

	localparam logic [7:0] FRAME_HEADER = 8'h7B;
	localparam logic [7:0] FRAME_TAIL   = 8'h7D;

	typedef struct packed {
		logic load;
		logic shift;
	} ffd_cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DROP = 3'b010,
		ST_SCAN = 3'b100
	} ffd_state_t;

endpackage

>>> src/ffd_cell.sv
// ----------------------------------------------------------------------------
// ffd_cell
// One byte of the frame window: loads a received byte or takes its right
// neighbor's byte when the window shifts.
// ----------------------------------------------------------------------------
module ffd_cell (
	input  logic                  clk,
	input  ffd_pkg::ffd_cell_ctl_t ctl,
	input  logic [7:0]            din_byte,
	input  logic [7:0]            next_byte,
	output logic [7:0]            byte_q
);
	import ffd_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= next_byte;
		end else if (ctl.load) begin
			byte_q <= din_byte;
		end
	end

endmodule

>>> src/feedback_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// feedback_frame_deframer_core
// Header/tail/XOR-checksum frame parser for the chassis feedback link.
// ----------------------------------------------------------------------------
// Input channel: one serial byte per request on rx_byte (in_valid/in_stall).
// Bytes are held in a row of 24 byte cells; leading bytes other than the
// header 0x7B are dropped. A running XOR of the held bytes makes the
// checksum test a single compare when the 24th byte arrives.
// Output channel: one request of ten signed 16-bit words (out_valid/
// out_stall) per frame that passes the tail and checksum test.
// Throughput: one byte per cycle while frames fill. The frame result is
// registered and appears the cycle after its tail byte is taken.
// A failed check holds in_stall high while the cell row shifts one byte a
// cycle: ST_DROP first drops the leading byte, then ST_SCAN drops any byte
// that is not a header and stops when it sees the header or the empty row.
// A pending result holds its words while out_stall is high; bytes keep
// being taken, except the byte that would close the next frame.
// Reset (arst_n low) empties the window and clears out_valid.
// ----------------------------------------------------------------------------
module feedback_frame_deframer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] vel_x,
	output logic signed [15:0] vel_y,
	output logic signed [15:0] yaw_rate,
	output logic signed [15:0] imu_word0,
	output logic signed [15:0] imu_word1,
	output logic signed [15:0] imu_word2,
	output logic signed [15:0] imu_word3,
	output logic signed [15:0] imu_word4,
	output logic signed [15:0] imu_word5,
	output logic signed [15:0] battery_mv
);
	import ffd_pkg::*;

	ffd_state_t          state_q, state_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [7:0]          acc_q, acc_d;
	logic                out_valid_q;
	logic [15:0]         words_q [WORD_COUNT];
	logic [7:0]          cell_byte [FRAME_LEN];
	ffd_cell_ctl_t       cell_ctl [FRAME_LEN];
	logic                take, write_en, shift_en, emit;

	assign in_stall = (state_q != ST_IDLE) ||
		(out_valid_q && (fill_q == FILL_W'(TAIL_POS)));
	assign take = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		acc_d    = acc_q;
		write_en = 1'b0;
		shift_en = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take && !((fill_q == '0) && (rx_byte != FRAME_HEADER))) begin
					if (fill_q == FILL_W'(TAIL_POS)) begin
						if ((rx_byte == FRAME_TAIL) && (acc_q == '0)) begin
							emit   = 1'b1;
							fill_d = '0;
							acc_d  = '0;
						end else begin
							write_en = 1'b1;
							fill_d   = FILL_W'(FRAME_LEN);
							acc_d    = acc_q ^ rx_byte;
							state_d  = ST_DROP;
						end
					end else begin
						write_en = 1'b1;
						fill_d   = fill_q + 1'b1;
						acc_d    = acc_q ^ rx_byte;
					end
				end
			end
			ST_DROP: begin
				shift_en = 1'b1;
				fill_d   = fill_q - 1'b1;
				acc_d    = acc_q ^ cell_byte[0];
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if ((fill_q == '0) || (cell_byte[0] == FRAME_HEADER)) begin
					state_d = ST_IDLE;
				end else begin
					shift_en = 1'b1;
					fill_d   = fill_q - 1'b1;
					acc_d    = acc_q ^ cell_byte[0];
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		logic [7:0] next_byte;
		if (i == FRAME_LEN - 1) begin : g_last
			assign next_byte = 8'h00;
		end else begin : g_mid
			assign next_byte = cell_byte[i+1];
		end
		assign cell_ctl[i].shift = shift_en;
		assign cell_ctl[i].load  = write_en && (fill_q == FILL_W'(i));
		ffd_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.din_byte  (rx_byte),
			.next_byte (next_byte),
			.byte_q    (cell_byte[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			acc_q   <= acc_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int k = 0; k < WORD_COUNT; k++) begin
				words_q[k] <= {cell_byte[2 + 2*k], cell_byte[3 + 2*k]};
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign vel_x      = words_q[0];
	assign vel_y      = words_q[1];
	assign yaw_rate   = words_q[2];
	assign imu_word0  = words_q[3];
	assign imu_word1  = words_q[4];
	assign imu_word2  = words_q[5];
	assign imu_word3  = words_q[6];
	assign imu_word4  = words_q[7];
	assign imu_word5  = words_q[8];
	assign battery_mv = words_q[9];

endmodule

>>> src/ffd_checker.sv
// ----------------------------------------------------------------------------
// ffd_checker
// Port-level checks of the feedback frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ffd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         rx_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] vel_x,
	input logic signed [15:0] battery_mv
);
	import ffd_pkg::*;

	a_reset_clear: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vel_x) && $stable(battery_mv))
		else $error("stalled result changed");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result followed by another at once");

	a_tail_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && (rx_byte == FRAME_TAIL)))
		else $error("result without a tail byte");

endmodule

bind feedback_frame_deframer_core ffd_checker u_ffd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.rx_byte    (rx_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.vel_x      (vel_x),
	.battery_mv (battery_mv)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for feedback_frame_deframer_core. A byte stream of
// noise, good frames, frames with a bad tail or a bad checksum and cut-off
// frames is fed in. Each taken byte runs through a bench-side copy of the
// window logic, and every frame that should pass is queued and compared
// word by word with the block's output. Both sides idle at random, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffd_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int BYTE_TARGET = 850;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	typedef logic [0:WORD_COUNT-1][15:0] frame_words_t;

	typedef enum logic [2:0] {
		ROW_NOISE,
		ROW_FRAME,
		ROW_BAD_TAIL,
		ROW_BAD_SUM,
		ROW_SHORT
	} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		logic [7:0]   lead;
		frame_words_t words;
		bit           typed;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] yaw_rate;
	logic signed [15:0] imu_word0;
	logic signed [15:0] imu_word1;
	logic signed [15:0] imu_word2;
	logic signed [15:0] imu_word3;
	logic signed [15:0] imu_word4;
	logic signed [15:0] imu_word5;
	logic signed [15:0] battery_mv;

	logic [7:0]   rx_window [FRAME_LEN];
	int           rx_fill;
	frame_words_t expected_frames [$];
	logic [7:0]   tx_bytes [$];
	int           bytes_sent;
	int           frames_seen;
	int           error_count;
	int           cycle_count;
	int           stall_left;
	bit           quiet_in;
	bit           quiet_out;
	logic         hold_off = 1'b0;

	string field_names [0:WORD_COUNT-1] = '{"vel_x", "vel_y", "yaw_rate", "imu_word0",
		"imu_word1", "imu_word2", "imu_word3", "imu_word4", "imu_word5", "battery_mv"};

	stim_row_t directed_rows [0:8] = '{
		'{ROW_NOISE, 8'h00, '0, 1'b1},
		'{ROW_NOISE, 8'hFF, '0, 1'b1},
		'{ROW_NOISE, FRAME_TAIL, '0, 1'b1},
		'{ROW_FRAME, 8'h00, {WORD_COUNT{16'h7FFF}}, 1'b1},
		'{ROW_FRAME, 8'hFF, {WORD_COUNT{16'h8000}}, 1'b1},
		'{ROW_FRAME, FRAME_HEADER, {16'h0000, 16'hFFFF, 16'h0001, 16'h7B7D, 16'h7D7B,
			16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00, 16'h5AA5}, 1'b1},
		'{ROW_BAD_TAIL, 8'h00, {WORD_COUNT{16'h1357}}, 1'b0},
		'{ROW_BAD_SUM, FRAME_HEADER, {WORD_COUNT{16'h7B00}}, 1'b0},
		'{ROW_FRAME, 8'h42, {WORD_COUNT{16'hA55A}}, 1'b0}
	};

	feedback_frame_deframer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.yaw_rate   (yaw_rate),
		.imu_word0  (imu_word0),
		.imu_word1  (imu_word1),
		.imu_word2  (imu_word2),
		.imu_word3  (imu_word3),
		.imu_word4  (imu_word4),
		.imu_word5  (imu_word5),
		.battery_mv (battery_mv)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// window model: returns 1 with the frame words when a frame passes
	function automatic bit deframe_byte(input logic [7:0] b, output frame_words_t words);
		logic [7:0] sum;
		bit         ok;
		words = '0;
		if (rx_fill == 0 && b != FRAME_HEADER) begin
			return 1'b0;
		end
		rx_window[rx_fill] = b;
		rx_fill++;
		if (rx_fill < FRAME_LEN) begin
			return 1'b0;
		end
		sum = '0;
		for (int i = 0; i < CHECK_POS; i++) begin
			sum ^= rx_window[i];
		end
		ok = (rx_window[TAIL_POS] == FRAME_TAIL) && (sum == rx_window[CHECK_POS]);
		if (ok) begin
			for (int k = 0; k < WORD_COUNT; k++) begin
				words[k] = {rx_window[2 + 2 * k], rx_window[3 + 2 * k]};
			end
			rx_fill = 0;
			return 1'b1;
		end
		do begin
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				rx_window[i] = rx_window[i + 1];
			end
			rx_fill--;
		end while (rx_fill > 0 && rx_window[0] != FRAME_HEADER);
		return 1'b0;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic frame_words_t rand_words();
		frame_words_t w;
		for (int k = 0; k < WORD_COUNT; k++) begin
			case ($urandom_range(11))
				0: w[k] = 16'h7FFF;
				1: w[k] = 16'h8000;
				2: w[k] = 16'h0000;
				3: w[k] = 16'hFFFF;
				default: w[k] = 16'($urandom);
			endcase
		end
		return w;
	endfunction

	function automatic void build_segment(input row_kind_t kind, input logic [7:0] lead,
		input frame_words_t words);
		logic [7:0] frame [FRAME_LEN];
		logic [7:0] sum;
		int         cut;
		if (kind == ROW_NOISE) begin
			tx_bytes.push_back(lead);
			return;
		end
		frame[0] = FRAME_HEADER;
		frame[1] = lead;
		for (int k = 0; k < WORD_COUNT; k++) begin
			frame[2 + 2 * k] = words[k][15:8];
			frame[3 + 2 * k] = words[k][7:0];
		end
		sum = '0;
		for (int i = 0; i < CHECK_POS; i++) begin
			sum ^= frame[i];
		end
		frame[CHECK_POS] = sum;
		frame[TAIL_POS] = FRAME_TAIL;
		if (kind == ROW_BAD_TAIL) begin
			frame[TAIL_POS] ^= 8'($urandom_range(1, 255));
		end
		if (kind == ROW_BAD_SUM) begin
			frame[CHECK_POS] ^= 8'($urandom_range(1, 255));
		end
		cut = (kind == ROW_SHORT) ? $urandom_range(2, FRAME_LEN - 1) : FRAME_LEN;
		for (int i = 0; i < cut; i++) begin
			tx_bytes.push_back(frame[i]);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit predicted);
		int           gap;
		bit           passed;
		frame_words_t w;
		if ($urandom_range(63) == 0) begin
			quiet_in = !quiet_in;
		end
		gap = pick_gap(quiet_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		passed = deframe_byte(b, w);
		if (passed && predicted) begin
			expected_frames.push_back(w);
		end
	endtask

	task automatic send_pending(input bit predicted);
		while (tx_bytes.size() > 0) begin
			send_byte(tx_bytes.pop_front(), predicted);
		end
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		rx_fill = 0;
		bytes_sent = 0;
		quiet_in = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			build_segment(directed_rows[i].kind, directed_rows[i].lead, directed_rows[i].words);
			send_pending(!directed_rows[i].typed);
			if (directed_rows[i].typed && directed_rows[i].kind == ROW_FRAME) begin
				expected_frames.push_back(directed_rows[i].words);
			end
		end

		while (bytes_sent < BYTE_TARGET) begin
			r = $urandom_range(99);
			if (r < 72) begin
				build_segment(ROW_FRAME, 8'($urandom), rand_words());
			end else if (r < 80) begin
				build_segment(ROW_BAD_TAIL, 8'($urandom), rand_words());
			end else if (r < 88) begin
				build_segment(ROW_BAD_SUM, 8'($urandom), rand_words());
			end else if (r < 94) begin
				repeat ($urandom_range(1, 6)) build_segment(ROW_NOISE, 8'($urandom), '0);
			end else begin
				build_segment(ROW_SHORT, 8'($urandom), rand_words());
			end
			send_pending(1'b1);
		end

		in_valid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// long receiver hold-off so the window fills and the input stalls
	initial begin
		wait (frames_seen >= 5);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		frame_words_t got;
		frame_words_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {vel_x, vel_y, yaw_rate, imu_word0, imu_word1, imu_word2, imu_word3,
				imu_word4, imu_word5, battery_mv};
			frames_seen++;
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected frame, expected none, got %h", $time, got);
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				for (int k = 0; k < WORD_COUNT; k++) begin
					if (got[k] !== want[k]) begin
						$display("%0t: %s expected %0d got %0d", $time, field_names[k],
							$signed(want[k]), $signed(got[k]));
						error_count++;
					end
				end
			end
		end
		if ($urandom_range(127) == 0) begin
			quiet_out = !quiet_out;
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (!quiet_out && $urandom_range(3) == 0) begin
			stall_left = pick_gap(1'b0);
		end
		out_stall <= hold_off || (stall_left > 0);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule

>>> feedback_frame_deframer_core.f
src/ffd_pkg.sv
src/ffd_cell.sv
src/feedback_frame_deframer_core.sv
src/ffd_checker.sv
tb/sv/tb_top.sv
